// File: hw/rtl/gcbs_pkg.sv
// shared constants for the glyph code binary search block
package gcbs_pkg;

   // default table depth
   localparam int unsigned MAX_GLYPHS_DEF = 8192;

   // field widths
   localparam int unsigned SLOT_W  = 13;
   localparam int unsigned CODE_W  = 16;
   localparam int unsigned COUNT_W = 14;
   localparam int unsigned CSR_W   = 14;
   localparam int unsigned CSR_A_W = 1;

   // transaction function codes
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // configuration register indexes
   localparam logic [CSR_A_W-1:0] CSR_ENTRY_COUNT    = 1'b0;
   localparam logic [CSR_A_W-1:0] CSR_FALLBACK_INDEX = 1'b1;

   typedef logic [CODE_W-1:0] code_type;
   typedef logic [SLOT_W-1:0] slot_type;

endpackage

// File: hw/rtl/gcbs_ram.sv
// single port code table memory with registered read data
module gcbs_ram #(
   parameter int unsigned DEPTH  = gcbs_pkg::MAX_GLYPHS_DEF,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   addr,
   input  gcbs_pkg::code_type  wr_data,
   output gcbs_pkg::code_type  rd_data
);
   import gcbs_pkg::*;

   code_type mem [DEPTH];
   code_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/glyph_code_binary_search_top.sv
// glyph code table with binary search lookup, top level
//
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  req_func, req_slot, req_code
// rsp      out        rsp_valid / rsp_ready  rsp_glyph_slot, rsp_found
// csr      in         csr_we (no wait)       csr_addr, csr_wdata
//
// a write transaction gives no response
// a lookup makes p probes, p = 1 .. ceil(log2(count+1)), with one table
// read per probe on the single memory port (read data back in the cycle
// after the address)
// a lookup with zero count makes no probe and returns the fallback slot
// reset is synchronous and clears control and configuration registers;
// the table itself is not cleared and needs no pass after reset
// req_ready is low while a lookup runs; a finished response waits in the
// output register, so new transactions are taken while rsp is stalled
module glyph_code_binary_search_top #(
   parameter int unsigned MAX_GLYPHS = gcbs_pkg::MAX_GLYPHS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_func,
   input  gcbs_pkg::slot_type                   req_slot,
   input  gcbs_pkg::code_type                   req_code,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output gcbs_pkg::slot_type                   rsp_glyph_slot,
   output logic                                 rsp_found,
   // configuration writes
   input  logic                                 csr_we,
   input  logic [gcbs_pkg::CSR_A_W-1:0]         csr_addr,
   input  logic [gcbs_pkg::CSR_W-1:0]           csr_wdata
);
   import gcbs_pkg::*;

   // address width of the table and width of search bounds (0 .. MAX_GLYPHS)
   localparam int unsigned AW    = $clog2(MAX_GLYPHS);
   localparam int unsigned CW    = $clog2(MAX_GLYPHS + 1);
   localparam int unsigned CMP_W = (CW > COUNT_W) ? CW + 1 : COUNT_W + 1;
   localparam int unsigned SCM_W = (CW > SLOT_W) ? CW + 1 : SLOT_W + 1;

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // configuration registers
   logic [COUNT_W-1:0] entry_count_ff;
   slot_type           fallback_ff;

   // search state
   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [AW-1:0] mid_ff, mid_in;
   code_type      key_ff, key_in;
   slot_type      res_slot_ff, res_slot_in;
   logic          res_found_ff, res_found_in;

   // response register
   logic     rsp_valid_ff, rsp_valid_in;
   slot_type rsp_slot_ff, rsp_slot_in;
   logic     rsp_found_ff, rsp_found_in;

   // memory port
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   code_type      ram_rdata;

   // datapath
   logic          req_fire;
   logic          out_free;
   logic [CW-1:0] count_sat;
   logic [CW-1:0] first_mid;
   logic [CW-1:0] mid_ext;
   logic          probe_eq;
   logic          probe_lt;
   logic [CW-1:0] next_lo;
   logic [CW-1:0] next_hi;
   logic [CW-1:0] next_mid;
   logic          slot_ok;

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // count saturated to table depth
   assign count_sat = (CMP_W'(entry_count_ff) > CMP_W'(MAX_GLYPHS)) ?
                      CW'(MAX_GLYPHS) : CW'(entry_count_ff);

   // first probe over [0, count)
   assign first_mid = (count_sat - CW'(1)) >> 1;

   // one search step on the read data of the last probe
   assign mid_ext  = CW'(mid_ff);
   assign probe_eq = (ram_rdata == key_ff);
   assign probe_lt = (ram_rdata <  key_ff);
   assign next_lo  = probe_lt ? (mid_ext + CW'(1)) : lo_ff;
   assign next_hi  = probe_lt ? hi_ff : mid_ext;
   assign next_mid = next_lo + ((next_hi - next_lo - CW'(1)) >> 1);

   // writes at or past the table depth are dropped
   assign slot_ok = SCM_W'(req_slot) < SCM_W'(MAX_GLYPHS);

   // memory address: write slot, first probe, or next probe
   always_comb begin
      ram_we   = 1'b0;
      ram_addr = AW'(next_mid);
      if (state_ff == ST_IDLE) begin
         ram_we   = req_fire && (req_func == FUNC_WRITE) && slot_ok;
         ram_addr = (req_func == FUNC_WRITE) ? AW'(req_slot) : AW'(first_mid);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      res_slot_in  = res_slot_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_found_in = rsp_found_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_func == FUNC_LOOKUP)) begin
               key_in = req_code;
               lo_in  = '0;
               hi_in  = count_sat;
               mid_in = AW'(first_mid);
               if (count_sat == '0) begin
                  res_slot_in  = fallback_ff;
                  res_found_in = 1'b0;
                  state_in     = ST_FINISH;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (probe_eq) begin
               res_slot_in  = SLOT_W'(mid_ff);
               res_found_in = 1'b1;
               state_in     = ST_FINISH;
            end else if (next_lo < next_hi) begin
               lo_in  = next_lo;
               hi_in  = next_hi;
               mid_in = AW'(next_mid);
            end else begin
               res_slot_in  = fallback_ff;
               res_found_in = 1'b0;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hand the result over once the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = res_slot_ff;
               rsp_found_in = res_found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         entry_count_ff <= '0;
         fallback_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_ENTRY_COUNT:    entry_count_ff <= csr_wdata[COUNT_W-1:0];
               CSR_FALLBACK_INDEX: fallback_ff    <= csr_wdata[SLOT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      res_slot_ff  <= res_slot_in;
      res_found_ff <= res_found_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_found_ff <= rsp_found_in;
   end

   gcbs_ram #(
      .DEPTH  (MAX_GLYPHS),
      .ADDR_W (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (req_code),
      .rd_data (ram_rdata)
   );

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_glyph_slot = rsp_slot_ff;
   assign rsp_found      = rsp_found_ff;

`ifndef NO_ASSERTIONS
   // the probe window is never empty while searching
   a_window_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (lo_ff < hi_ff))
      else $error("search window empty");

   // the probe lies inside the window
   a_mid_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> ((mid_ext >= lo_ff) && (mid_ext < hi_ff)))
      else $error("probe outside search window");

   // a hit never points past the searched range
   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && res_found_ff) |-> (CMP_W'(res_slot_ff) < CMP_W'(count_sat)))
      else $error("hit slot beyond entry count");

   // a finished lookup reaches the output and frees the request side
   a_finish_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished lookup not handed to output");
`endif

endmodule
